[hw/rtl/sorted_array_priority_queue_unit_assert.svh]
// Assertion macros shared by the checker of the priority queue unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority queue check failed");

// Next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

[hw/rtl/spq_pkg.sv]
// Shared types and constants of the sorted-array priority queue unit.
// No dependencies; imported by every other file but the assertion header.
package spq_pkg;

  // Queue geometry
  localparam int DEPTH  = 8;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PRIO_W = 16;
  localparam int TAG_W  = 16;
  localparam int OCC_W  = 4;
  localparam int STAT_W = 2;

  // Operation codes of an input item
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } state_t;

  // Datapath command codes
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_ENQ       = 3'd1,
    CMD_DEQ       = 3'd2,
    CMD_REJ_FULL  = 3'd3,
    CMD_REJ_EMPTY = 3'd4
  } cmd_code_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    cmd_code_t code;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

  // One result item
  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] head_priority;
    logic [TAG_W-1:0]  head_tag;
    logic              queue_empty;
    logic              is_full;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

endpackage

[hw/rtl/spq_if.sv]
// Valid/ready channel interfaces for the request and response items.
// Depends on spq_pkg for field widths.
interface spq_req_if import spq_pkg::*;;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [PRIO_W-1:0] priority_req;
  logic [TAG_W-1:0]  task_tag;

  modport source (output valid, output operation, output priority_req,
                  output task_tag, input ready);
  modport sink   (input valid, input operation, input priority_req,
                  input task_tag, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [PRIO_W-1:0] head_priority;
  logic [TAG_W-1:0]  head_tag;
  logic              queue_empty;
  logic              is_full;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output head_priority,
                  output head_tag, output queue_empty, output is_full,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input head_priority,
                  input head_tag, input queue_empty, input is_full,
                  input occupancy, output ready);
endinterface

[hw/rtl/sorted_array_priority_queue_unit.sv]
// Sorted-array priority queue unit: up to DEPTH entries of priority and tag,
// highest priority at the head, equal priorities in arrival order.
//
// Channels: req carries one item (operation, priority_req, task_tag);
// operation OP_ENQ inserts the entry, OP_DEQ removes the head. rsp returns
// one item per request: status, head entry after the step (zero if empty),
// queue_empty, is_full and occupancy.
// Response: the response item is registered and valid in the cycle after the request is taken.
// Throughput: one item per cycle unless rsp stalls; each insert or remove
// is done at once by the shift-register cells, each with a priority compare.
// The response register decouples the sides: req.ready stays high while
// the held response is being taken in the same cycle.
// Stall: while rsp.valid is high and rsp.ready is low, the response holds
// and req.ready is low.
// Reset (rst, synchronous): the queue is emptied and no response is pending;
// no clearing pass is needed.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_datapath.
module sorted_array_priority_queue_unit import spq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  dp_cmd_t    cmd;
  dp_status_t stat;
  result_t    res;

  // Handshake control and command decode
  spq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_operation (req.operation),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Queue cells and result register
  spq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .priority_req (req.priority_req),
    .task_tag     (req.task_tag),
    .stat         (stat),
    .res          (res)
  );

  // Response payload
  assign rsp.status        = res.status;
  assign rsp.head_priority = res.head_priority;
  assign rsp.head_tag      = res.head_tag;
  assign rsp.queue_empty   = res.queue_empty;
  assign rsp.is_full       = res.is_full;
  assign rsp.occupancy     = res.occupancy;

endmodule

[hw/rtl/spq_ctrl.sv]
// Controller of the priority queue: handshake state and command decode.
// Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_operation,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  dp_status_t stat,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and command
  always_comb begin
    req_ready  = (state == ST_IDLE) || rsp_ready;
    rsp_valid  = (state == ST_HOLD);
    accept     = req_valid && req_ready;
    state_next = state;
    cmd.load   = accept;
    cmd.code   = CMD_NONE;
    if (accept) begin
      if (req_operation == OP_ENQ) begin
        cmd.code = stat.full ? CMD_REJ_FULL : CMD_ENQ;
      end else begin
        cmd.code = stat.empty ? CMD_REJ_EMPTY : CMD_DEQ;
      end
    end
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (rsp_ready && !accept) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/spq_datapath.sv]
// Datapath of the priority queue: sorted shift-register cells with a
// compare per cell, entry counter and result register. Depends on spq_pkg.
module spq_datapath import spq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [TAG_W-1:0]  task_tag,
  output dp_status_t        stat,
  output result_t           res
);

  logic [PRIO_W-1:0]      prio_cell      [DEPTH];
  logic [TAG_W-1:0]       tag_cell       [DEPTH];
  logic [PRIO_W-1:0]      prio_cell_next [DEPTH];
  logic [TAG_W-1:0]       tag_cell_next  [DEPTH];
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [DEPTH-1:0]       gt;
  logic [CNT_W+OCC_W-1:0] occ_ext;
  result_t                res_next;

  // Per-cell compare: new priority beats a stored entry
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count) && (priority_req > prio_cell[i]);
    end
  end

  // Cell update: shift down behind the insert point, or shift up on removal
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      prio_cell_next[i] = prio_cell[i];
      tag_cell_next[i]  = tag_cell[i];
    end
    count_next = count;
    case (cmd.code)
      CMD_ENQ: begin
        if (gt[0] || (count == '0)) begin
          prio_cell_next[0] = priority_req;
          tag_cell_next[0]  = task_tag;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (gt[i-1]) begin
            prio_cell_next[i] = prio_cell[i-1];
            tag_cell_next[i]  = tag_cell[i-1];
          end else if (gt[i] || (CNT_W'(i) == count)) begin
            prio_cell_next[i] = priority_req;
            tag_cell_next[i]  = task_tag;
          end
        end
        count_next = count + 1'b1;
      end
      CMD_DEQ: begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          prio_cell_next[i] = prio_cell[i+1];
          tag_cell_next[i]  = tag_cell[i+1];
        end
        count_next = count - 1'b1;
      end
      default: ;
    endcase
  end

  // Status toward the controller
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // Result item, from the state after the step
  assign occ_ext = {{OCC_W{1'b0}}, count_next};
  always_comb begin
    case (cmd.code)
      CMD_REJ_FULL:  res_next.status = STAT_FULL;
      CMD_REJ_EMPTY: res_next.status = STAT_EMPTY;
      default:       res_next.status = STAT_DONE;
    endcase
    res_next.queue_empty   = (count_next == '0);
    res_next.is_full       = (count_next == CNT_W'(DEPTH));
    res_next.occupancy     = occ_ext[OCC_W-1:0];
    res_next.head_priority = res_next.queue_empty ? '0 : prio_cell_next[0];
    res_next.head_tag      = res_next.queue_empty ? '0 : tag_cell_next[0];
  end

  // Entry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= count_next;
    end
  end

  // Cells and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < DEPTH; i++) begin
        prio_cell[i] <= prio_cell_next[i];
        tag_cell[i]  <= tag_cell_next[i];
      end
      res <= res_next;
    end
  end

endmodule

[hw/rtl/spq_checker.sv]
// Port-level checker of the priority queue unit and its bind.
// Depends on spq_pkg and the assertion macro header.
`include "sorted_array_priority_queue_unit_assert.svh"

module spq_checker import spq_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [STAT_W-1:0] rsp_status,
  input logic [PRIO_W-1:0] rsp_head_priority,
  input logic [TAG_W-1:0]  rsp_head_tag,
  input logic              rsp_queue_empty,
  input logic              rsp_is_full,
  input logic [OCC_W-1:0]  rsp_occupancy
);

  logic [STAT_W+PRIO_W+TAG_W+OCC_W+1:0] rsp_payload;
  logic                                 head_zero;
  logic                                 rsp_rejected;

  // Helper terms
  assign rsp_payload  = {rsp_status, rsp_head_priority, rsp_head_tag,
                         rsp_queue_empty, rsp_is_full, rsp_occupancy};
  assign head_zero    = (rsp_head_priority == '0) && (rsp_head_tag == '0);
  assign rsp_rejected = rsp_valid && (rsp_status == STAT_FULL);

  // A taken request always yields a response on the next cycle
  `SPQ_ASSERT_NEXT(a_rsp_follows, clk, rst, req_valid && req_ready, rsp_valid)

  // A stalled response keeps its item
  `SPQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

  // An empty queue reports a zero head
  `SPQ_ASSERT_NOW(a_empty_head, clk, rst, rsp_valid && rsp_queue_empty, head_zero && !rsp_is_full)

  // A rejected enqueue only happens on a full queue
  `SPQ_ASSERT_NOW(a_reject_full, clk, rst, rsp_rejected, rsp_is_full && !rsp_queue_empty)

endmodule

bind sorted_array_priority_queue_unit spq_checker u_spq_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_head_priority (rsp.head_priority),
  .rsp_head_tag      (rsp.head_tag),
  .rsp_queue_empty   (rsp.queue_empty),
  .rsp_is_full       (rsp.is_full),
  .rsp_occupancy     (rsp.occupancy)
);
